FILE: rtl/core/u16w8_pkg.sv
// Shared types, constants and byte encoding for the UTF-16 to WTF-8 transcoder.
package u16w8_pkg;

    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned QPTR_W    = $clog2(Q_DEPTH);
    localparam int unsigned MAX_BYTES = 6;

    localparam logic [5:0]  HIGH_TAG     = 6'b110110;
    localparam logic [5:0]  LOW_TAG      = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [20:0] LIM_ONE      = 21'h00007f;
    localparam logic [20:0] LIM_TWO      = 21'h0007ff;
    localparam logic [20:0] LIM_THREE    = 21'h00ffff;
    localparam logic [7:0]  LEAD_TWO     = 8'hc0;
    localparam logic [7:0]  LEAD_THREE   = 8'he0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hf0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [7:0]  SURR_LEAD    = 8'hed;
    localparam logic [7:0]  SURR_HI_MARK = 8'ha0;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_last;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_last;
    } t_out_req;

    // One encoded code point: b[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_point_enc;

    // One queued job: the full byte run caused by one accepted unit.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] seq;
        logic [2:0]                count;
        logic                      last;
    } t_job;

    function automatic t_point_enc encode_point(input logic [20:0] v);
        t_point_enc e;
        e = '0;
        if (v <= LIM_ONE) begin
            e.n    = 3'd1;
            e.b[0] = v[7:0];
        end else if (v <= LIM_TWO) begin
            e.n    = 3'd2;
            e.b[0] = LEAD_TWO | {3'b000, v[10:6]};
            e.b[1] = CONT_MARK | {2'b00, v[5:0]};
        end else if (v <= LIM_THREE) begin
            e.n    = 3'd3;
            e.b[0] = LEAD_THREE | {4'b0000, v[15:12]};
            e.b[1] = CONT_MARK | {2'b00, v[11:6]};
            e.b[2] = CONT_MARK | {2'b00, v[5:0]};
        end else begin
            e.n    = 3'd4;
            e.b[0] = LEAD_FOUR | {5'b00000, v[20:18]};
            e.b[1] = CONT_MARK | {2'b00, v[17:12]};
            e.b[2] = CONT_MARK | {2'b00, v[11:6]};
            e.b[3] = CONT_MARK | {2'b00, v[5:0]};
        end
        return e;
    endfunction

endpackage

FILE: rtl/core/utf16_to_wtf8_transcoder.sv
// Top level of the UTF-16 to WTF-8 transcoder.
//
// This block turns a stream of UTF-16 code units into WTF-8 bytes. Each input
// request carries one code unit and a flag for the last unit of the string; each
// output request carries one byte, a flag on the last byte caused by that unit,
// and a flag on the final byte of the string. A high surrogate is held back
// until the next unit arrives: followed by a low surrogate it becomes a
// four-byte supplementary character, and otherwise it is sent alone as three
// bytes, as are lone low surrogates. A high surrogate that ends the string is
// sent at once. The front end accepts one unit per cycle while its four-entry
// job queue has room, and a held high surrogate produces no bytes until the
// next unit. The back end sends exactly one byte per cycle while the queue holds
// a job and the output is not stalled. A unit yields one to three bytes for an
// ordinary character, four for a surrogate pair (all caused by its low unit),
// and up to six when a flushed surrogate precedes a new character. Sustained
// throughput is therefore set by the byte serializer. When the queue is empty,
// the first byte of an accepted unit passes through the job queue and then the
// output register. The output register holds the current byte while it is
// stalled; the next byte is taken from the queue only once the slot is free.
module utf16_to_wtf8_transcoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  u16w8_pkg::t_in_req  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output u16w8_pkg::t_out_req o_out_req
);

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    u16w8_pkg::t_job push_job;
    u16w8_pkg::t_job head_job;

    // Classification and surrogate pairing; builds the whole byte run per unit.
    u16w8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Decouples unit acceptance from byte output so each side stalls on its own.
    u16w8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // Byte serializer; the job leaves the queue with its last byte.
    u16w8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

FILE: rtl/core/u16w8_front.sv
// Front end: accepts code units, pairs surrogates and builds the byte run of each unit.
module u16w8_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  u16w8_pkg::t_in_req i_in_req,
    input  logic               i_q_full,
    output logic               o_push,
    output u16w8_pkg::t_job    o_job
);

    logic       r_high_pending;
    logic [9:0] r_held_bits;
    logic       n_high_pending;
    logic [9:0] n_held_bits;

    logic                  accept;
    logic                  is_high;
    logic                  is_low;
    logic                  pair;
    logic                  pre;
    logic                  hold;
    logic [20:0]           main_cp;
    u16w8_pkg::t_point_enc main_enc;
    logic [2:0]            main_n;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    assign is_high = (i_in_req.code_unit[15:10] == u16w8_pkg::HIGH_TAG);
    assign is_low  = (i_in_req.code_unit[15:10] == u16w8_pkg::LOW_TAG);
    assign pair    = r_high_pending && is_low;
    assign pre     = r_high_pending && !is_low;
    assign hold    = !pair && is_high && !i_in_req.unit_last;

    assign main_cp  = pair ? ({1'b0, r_held_bits, i_in_req.code_unit[9:0]} + u16w8_pkg::SUPP_BASE)
                           : {5'b00000, i_in_req.code_unit};
    assign main_enc = u16w8_pkg::encode_point(main_cp);
    assign main_n   = hold ? 3'd0 : main_enc.n;

    // A flushed high surrogate is always three bytes and goes first; the unit
    // that follows it is never part of a pair, so it needs at most three more.
    always_comb begin
        o_job      = '0;
        o_job.last = i_in_req.unit_last;
        if (pre) begin
            o_job.seq[0] = u16w8_pkg::SURR_LEAD;
            o_job.seq[1] = u16w8_pkg::SURR_HI_MARK | {4'b0000, r_held_bits[9:6]};
            o_job.seq[2] = u16w8_pkg::CONT_MARK | {2'b00, r_held_bits[5:0]};
            o_job.seq[3] = main_enc.b[0];
            o_job.seq[4] = main_enc.b[1];
            o_job.seq[5] = main_enc.b[2];
            o_job.count  = 3'd3 + main_n;
        end else begin
            o_job.seq[0] = main_enc.b[0];
            o_job.seq[1] = main_enc.b[1];
            o_job.seq[2] = main_enc.b[2];
            o_job.seq[3] = main_enc.b[3];
            o_job.count  = main_n;
        end
    end

    assign o_push = accept && (o_job.count != 3'd0);

    always_comb begin
        n_high_pending = r_high_pending;
        n_held_bits    = r_held_bits;
        if (accept) begin
            n_high_pending = hold;
            n_held_bits    = hold ? i_in_req.code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_held_bits    <= 10'd0;
        end else begin
            r_high_pending <= n_high_pending;
            r_held_bits    <= n_held_bits;
        end
    end

endmodule

FILE: rtl/core/u16w8_queue.sv
// Job queue between the front end and the byte serializer.
module u16w8_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u16w8_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output u16w8_pkg::t_job o_head
);

    u16w8_pkg::t_job r_mem [u16w8_pkg::Q_DEPTH];

    logic [u16w8_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [u16w8_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [u16w8_pkg::QPTR_W:0]   r_count;
    logic [u16w8_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [u16w8_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [u16w8_pkg::QPTR_W:0]   n_count;

    assign o_full  = (r_count == (u16w8_pkg::QPTR_W + 1)'(u16w8_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/core/u16w8_back.sv
// Back end: sends queued job bytes via an output register, one per cycle unless stalled.
module u16w8_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  u16w8_pkg::t_job     i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output u16w8_pkg::t_out_req o_out_req
);

    logic                r_out_valid;
    u16w8_pkg::t_out_req r_out_req;
    logic [2:0]          r_idx;
    logic                n_out_valid;
    u16w8_pkg::t_out_req n_out_req;
    logic [2:0]          n_idx;

    logic slot_free;
    logic send;
    logic run_end;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign send      = slot_free && !i_q_empty;
    assign run_end   = (r_idx == (i_head.count - 3'd1));
    assign o_pop     = send && run_end;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;
        n_idx       = r_idx;
        if (slot_free) begin
            n_out_valid = send;
        end
        if (send) begin
            n_out_req.out_byte    = i_head.seq[r_idx];
            n_out_req.run_last    = run_end;
            n_out_req.string_last = run_end && i_head.last;
            n_idx                 = run_end ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the UTF-16 to WTF-8 transcoder with a byte scoreboard.
`timescale 1ns / 100ps

module testbench;

    // Surrogate tags are the top six bits of a code unit.
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_START   = 21'h010000;
    localparam logic [20:0] ONE_BYTE_MAX = 21'h00007f;
    localparam logic [20:0] TWO_BYTE_MAX = 21'h0007ff;
    localparam logic [20:0] BMP_MAX      = 21'h00ffff;

    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned PHASE_UNITS    = 150;

    // The scoreboard keeps its own copy of the surrogate state and turns each
    // accepted request into the bytes that it must cause, in order.
    class wtf8_scoreboard;
        u16w8_pkg::t_out_req expected_bytes[$];
        logic [7:0]          run_bytes[$];
        logic                high_held;
        logic [9:0]          high_bits;
        int unsigned         mismatches;
        int unsigned         bytes_checked;
        int unsigned         units_noted;
        int unsigned         pairs_joined;
        int unsigned         lone_surrogates;
        int unsigned         strings_ended;

        function new();
            high_held       = 1'b0;
            high_bits       = '0;
            mismatches      = 0;
            bytes_checked   = 0;
            units_noted     = 0;
            pairs_joined    = 0;
            lone_surrogates = 0;
            strings_ended   = 0;
        endfunction

        // Appends the UTF-8 form of one scalar (or lone surrogate) to the run.
        function void add_point(input logic [20:0] cp);
            if (cp <= ONE_BYTE_MAX) begin
                run_bytes.push_back(cp[7:0]);
            end else if (cp <= TWO_BYTE_MAX) begin
                run_bytes.push_back({3'b110, cp[10:6]});
                run_bytes.push_back({2'b10, cp[5:0]});
            end else if (cp <= BMP_MAX) begin
                run_bytes.push_back({4'b1110, cp[15:12]});
                run_bytes.push_back({2'b10, cp[11:6]});
                run_bytes.push_back({2'b10, cp[5:0]});
            end else begin
                run_bytes.push_back({5'b11110, cp[20:18]});
                run_bytes.push_back({2'b10, cp[17:12]});
                run_bytes.push_back({2'b10, cp[11:6]});
                run_bytes.push_back({2'b10, cp[5:0]});
            end
        endfunction

        function void note_unit(input u16w8_pkg::t_in_req req);
            logic                is_high;
            logic                is_low;
            u16w8_pkg::t_out_req exp_byte;
            is_high = (req.code_unit[15:10] == HIGH_SURR_TAG);
            is_low  = (req.code_unit[15:10] == LOW_SURR_TAG);
            run_bytes.delete();
            units_noted++;
            if (high_held && is_low) begin
                add_point(SUPP_START + {1'b0, high_bits, req.code_unit[9:0]});
                high_held = 1'b0;
                high_bits = '0;
                pairs_joined++;
            end else begin
                if (high_held) begin
                    // The held high surrogate goes out alone before this unit.
                    add_point({5'd0, HIGH_SURR_TAG, high_bits});
                    high_held = 1'b0;
                    high_bits = '0;
                    lone_surrogates++;
                end
                if (is_high && !req.unit_last) begin
                    high_held = 1'b1;
                    high_bits = req.code_unit[9:0];
                end else begin
                    add_point({5'd0, req.code_unit});
                    if (is_high || is_low) begin
                        lone_surrogates++;
                    end
                end
            end
            if (req.unit_last) begin
                strings_ended++;
            end
            foreach (run_bytes[k]) begin
                exp_byte.out_byte    = run_bytes[k];
                exp_byte.run_last    = (k == run_bytes.size() - 1);
                exp_byte.string_last = (k == run_bytes.size() - 1) && req.unit_last;
                expected_bytes.push_back(exp_byte);
            end
        endfunction

        function void check_byte(input u16w8_pkg::t_out_req got);
            u16w8_pkg::t_out_req exp_byte;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h (run_last %b, string_last %b)",
                         $time, got.out_byte, got.run_last, got.string_last);
                mismatches++;
                return;
            end
            exp_byte = expected_bytes.pop_front();
            bytes_checked++;
            if (got.out_byte !== exp_byte.out_byte) begin
                $display("%0t: out_byte expected %h, got %h",
                         $time, exp_byte.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.run_last !== exp_byte.run_last) begin
                $display("%0t: run_last expected %b, got %b",
                         $time, exp_byte.run_last, got.run_last);
                mismatches++;
            end
            if (got.string_last !== exp_byte.string_last) begin
                $display("%0t: string_last expected %b, got %b",
                         $time, exp_byte.string_last, got.string_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    u16w8_pkg::t_in_req  in_req      = '0;
    logic                out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    u16w8_pkg::t_out_req o_out_req;

    // Idle percentages for each side; the main sequence changes them per phase.
    int unsigned src_idle_pct = 24;
    int unsigned dst_idle_pct = 62;

    // The main sequence raises hold_req; the receiver then counts out the
    // long stall on its own.
    logic        hold_req  = 1'b0;
    int unsigned hold_left = 0;

    int unsigned idle_cycles = 0;
    int unsigned units_sent  = 0;

    wtf8_scoreboard sb;

    utf16_to_wtf8_transcoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (o_out_req)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: the stall changes only at the falling edge. A requested hold
    // keeps the output stalled long enough for the job queue to fill.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall = 1'b1;
        end else begin
            out_stall = ($urandom_range(99) < dst_idle_pct);
        end
    end

    // Every byte that leaves the block is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            sb.check_byte(o_out_req);
        end
    end

    // The watchdog only trips when neither side has moved a request for a
    // long time, which no correct run comes near.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("** utf16_to_wtf8_transcoder: FAILED **");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests need no glitch.
    task automatic send_unit(input logic [15:0] unit, input logic unit_last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid            = 1'b1;
        in_req.code_unit    = unit;
        in_req.unit_last    = unit_last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_unit(in_req);
        units_sent++;
        @(negedge i_clk);
    endtask

    // One string of random characters. Most characters are well formed;
    // a few are lone surrogates or arbitrary 16-bit values, which break pairs.
    task automatic send_string(input int unsigned n_chars);
        logic [15:0] units[$];
        int unsigned pick;
        for (int c = 0; c < n_chars; c++) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                units.push_back(16'($urandom_range(16'h007f)));
            end else if (pick < 40) begin
                units.push_back(16'($urandom_range(16'h07ff, 16'h0080)));
            end else if (pick < 60) begin
                if ($urandom_range(1)) begin
                    units.push_back(16'($urandom_range(16'hd7ff, 16'h0800)));
                end else begin
                    units.push_back(16'($urandom_range(16'hffff, 16'he000)));
                end
            end else if (pick < 85) begin
                units.push_back({HIGH_SURR_TAG, 10'($urandom)});
                units.push_back({LOW_SURR_TAG, 10'($urandom)});
            end else if (pick < 92) begin
                units.push_back({HIGH_SURR_TAG, 10'($urandom)});
            end else if (pick < 97) begin
                units.push_back({LOW_SURR_TAG, 10'($urandom)});
            end else begin
                units.push_back(16'($urandom));
            end
        end
        foreach (units[k]) begin
            send_unit(units[k], k == units.size() - 1);
        end
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.expected_bytes.size() > 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int unsigned phase_goal;
        sb = new();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: byte-length boundaries, the lowest and highest
        // pairs, lone lows, a held high flushed before one- and three-byte
        // characters, a high followed by another high, and a high surrogate
        // that ends the string (alone and right after a held high).
        send_unit(16'h0000, 1'b1);
        send_unit(16'h007f, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hffff, 1'b1);
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b1);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdfff, 1'b1);
        send_unit(16'hd800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hffff, 1'b0);
        send_unit(16'hda55, 1'b0);
        send_unit(16'hd9aa, 1'b0);
        send_unit(16'hdbff, 1'b1);
        send_unit(16'hdaaa, 1'b1);
        send_unit(16'hd955, 1'b0);
        send_unit(16'he000, 1'b1);
        send_unit(16'hd7ff, 1'b1);

        // The sender pauses here until every byte of the directed part is out.
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 24;
                    dst_idle_pct = 62;
                end
                1: begin
                    src_idle_pct = 62;
                    dst_idle_pct = 24;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            phase_goal = units_sent + PHASE_UNITS;

            if (phase == 0) begin
                // Long output hold while the sender keeps offering requests
                // back to back, so the job queue fills and the input stalls.
                src_idle_pct = 0;
                hold_req     = 1'b1;
                repeat (4) send_string(5);
                src_idle_pct = 24;
            end

            while (units_sent < phase_goal) begin
                if ($urandom_range(19) == 0) begin
                    send_string($urandom_range(30, 10));
                end else begin
                    send_string($urandom_range(8, 1));
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d code units in %0d strings; checked %0d bytes.",
                 units_sent, sb.strings_ended, sb.bytes_checked);
        $display("Joined %0d surrogate pairs and encoded %0d lone surrogates.",
                 sb.pairs_joined, sb.lone_surrogates);
        if (sb.expected_bytes.size() > 0) begin
            $display("%0t: %0d expected bytes never arrived",
                     $time, sb.expected_bytes.size());
        end
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
            $display("** utf16_to_wtf8_transcoder: PASSED **");
        end else begin
            $display("** utf16_to_wtf8_transcoder: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/u16w8_pkg.sv
rtl/core/u16w8_front.sv
rtl/core/u16w8_queue.sv
rtl/core/u16w8_back.sv
rtl/core/utf16_to_wtf8_transcoder.sv
dv/testbench.sv
